@@ rtl/core/lnps_pkg.sv @@
`timescale 1ns / 1ps

package lnps_pkg;

    // Size of the held-note list and the octave used to fold low notes.
    localparam int MAX_NOTES = 8;
    localparam int OCTAVE    = 12;

    localparam int NOTE_W     = 7;
    localparam int NOTE_RANGE = 2 ** NOTE_W;
    localparam int PERIOD_W   = 14;
    localparam int CNT_W      = $clog2(MAX_NOTES + 1);
    localparam int IDX_W      = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;

    localparam int IN_TDATA_W  = ((NOTE_W + 7) / 8) * 8;
    localparam int OUT_BITS    = PERIOD_W + NOTE_W + CNT_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Event kinds carried on s_tuser.
    localparam logic KIND_NOTE_ON  = 1'b0;
    localparam logic KIND_NOTE_OFF = 1'b1;

    typedef logic [NOTE_W-1:0]   note_t;
    typedef logic [PERIOD_W-1:0] period_t;
    typedef logic [CNT_W-1:0]    count_t;
    typedef logic [IDX_W-1:0]    slot_t;

    // Outputs of the shared compare and subtract unit.
    typedef struct packed {
        logic  eq;
        logic  lt;
        note_t diff;
    } alu_res_t;

    // One finished result; period sits in the lowest bits.
    typedef struct packed {
        count_t  held_count;
        note_t   active_note;
        period_t period;
    } result_t;

    typedef logic [NOTE_RANGE-1:0][NOTE_W-1:0] mod_tab_t;

    function automatic mod_tab_t build_mod_table();
        mod_tab_t t;
        for (int i = 0; i < NOTE_RANGE; i++) begin
            t[i] = NOTE_W'(i % OCTAVE);
        end
        return t;
    endfunction

    // Residue of every note number modulo the octave size.
    localparam mod_tab_t MOD_TABLE = build_mod_table();

    localparam period_t PERIOD_TABLE [NOTE_RANGE] = '{
        14'd10192, 14'd9620, 14'd9080, 14'd8570, 14'd8089, 14'd7635, 14'd7206, 14'd6802,
        14'd6420,  14'd6060, 14'd5719, 14'd5398, 14'd5095, 14'd4809, 14'd4539, 14'd4284,
        14'd4044,  14'd3817, 14'd3603, 14'd3400, 14'd3209, 14'd3029, 14'd2859, 14'd2699,
        14'd2547,  14'd2404, 14'd2269, 14'd2142, 14'd2021, 14'd1908, 14'd1801, 14'd1700,
        14'd1604,  14'd1514, 14'd1429, 14'd1349, 14'd1273, 14'd1202, 14'd1134, 14'd1070,
        14'd1010,  14'd953,  14'd900,  14'd849,  14'd802,  14'd757,  14'd714,  14'd674,
        14'd636,   14'd600,  14'd567,  14'd535,  14'd505,  14'd476,  14'd449,  14'd424,
        14'd400,   14'd378,  14'd357,  14'd336,  14'd318,  14'd300,  14'd283,  14'd267,
        14'd252,   14'd238,  14'd224,  14'd212,  14'd200,  14'd188,  14'd178,  14'd168,
        14'd158,   14'd149,  14'd141,  14'd133,  14'd125,  14'd118,  14'd112,  14'd105,
        14'd99,    14'd94,   14'd88,   14'd83,   14'd79,   14'd74,   14'd70,   14'd66,
        14'd62,    14'd59,   14'd55,   14'd52,   14'd49,   14'd46,   14'd44,   14'd41,
        14'd39,    14'd37,   14'd34,   14'd32,   14'd31,   14'd29,   14'd27,   14'd26,
        14'd24,    14'd23,   14'd21,   14'd20,   14'd19,   14'd18,   14'd17,   14'd16,
        14'd15,    14'd14,   14'd13,   14'd12,   14'd12,   14'd11,   14'd10,   14'd10,
        14'd9,     14'd8,    14'd8,    14'd7,    14'd7,    14'd6,    14'd6,    14'd6
    };

endpackage

@@ rtl/core/lnps_ram.sv @@
`timescale 1ns / 1ps

module lnps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                     aclk,
    input  logic                                     wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/lnps_alu.sv @@
`timescale 1ns / 1ps

// Shared compare and subtract unit: note match during the search, and the
// offset test and subtraction when the table index is formed.
module lnps_alu (
    input  lnps_pkg::note_t    a,
    input  lnps_pkg::note_t    b,
    output lnps_pkg::alu_res_t res
);

    always_comb begin
        res.eq   = (a == b);
        res.lt   = (a < b);
        res.diff = a - b;
    end

endmodule

@@ rtl/core/lnps_ctrl.sv @@
`timescale 1ns / 1ps

module lnps_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic                start_kind,
    input  lnps_pkg::note_t     start_note,
    input  lnps_pkg::note_t     note_offset,
    input  logic                out_free,
    output logic                idle,
    output logic                done,
    output lnps_pkg::result_t   result
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SRD  = 4'd1;
    localparam logic [3:0] S_SCMP = 4'd2;
    localparam logic [3:0] S_MRD  = 4'd3;
    localparam logic [3:0] S_MWR  = 4'd4;
    localparam logic [3:0] S_TRD  = 4'd5;
    localparam logic [3:0] S_TIDX = 4'd6;
    localparam logic [3:0] S_TPER = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    localparam lnps_pkg::count_t CNT_ONE = lnps_pkg::CNT_W'(1);
    localparam lnps_pkg::count_t CNT_TWO = lnps_pkg::CNT_W'(2);
    localparam lnps_pkg::count_t CNT_MAX = lnps_pkg::CNT_W'(lnps_pkg::MAX_NOTES);

    logic [3:0]          state_reg, state_next;
    lnps_pkg::count_t    count_reg, count_next;
    lnps_pkg::slot_t     ptr_reg, ptr_next;
    lnps_pkg::note_t     note_reg, note_next;
    lnps_pkg::note_t     top_reg, top_next;
    lnps_pkg::note_t     idx_reg, idx_next;
    lnps_pkg::period_t   period_reg, period_next;

    logic                ram_we;
    lnps_pkg::slot_t     ram_waddr;
    lnps_pkg::note_t     ram_wdata;
    lnps_pkg::slot_t     ram_raddr;
    lnps_pkg::note_t     ram_rdata;

    lnps_pkg::note_t     alu_b;
    lnps_pkg::alu_res_t  alu_res;
    lnps_pkg::count_t    ptr_ext;
    lnps_pkg::count_t    top_addr;

    lnps_ram #(
        .WIDTH (lnps_pkg::NOTE_W),
        .DEPTH (lnps_pkg::MAX_NOTES)
    ) u_list (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    lnps_alu u_alu (
        .a   (ram_rdata),
        .b   (alu_b),
        .res (alu_res)
    );

    assign ptr_ext  = lnps_pkg::CNT_W'(ptr_reg);
    assign top_addr = count_reg - CNT_ONE;
    assign alu_b    = (state_reg == S_TIDX) ? note_offset : note_reg;

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        ptr_next    = ptr_reg;
        note_next   = note_reg;
        top_next    = top_reg;
        idx_next    = idx_reg;
        period_next = period_reg;
        ram_we      = 1'b0;
        ram_waddr   = ptr_reg;
        ram_wdata   = ram_rdata;
        ram_raddr   = ptr_reg;

        case (state_reg)
            S_IDLE: begin
                if (start) begin
                    note_next = start_note;
                    ptr_next  = '0;
                    if (start_kind == lnps_pkg::KIND_NOTE_ON) begin
                        // A full list ignores the note but still reports.
                        if (count_reg < CNT_MAX) begin
                            ram_we     = 1'b1;
                            ram_waddr  = count_reg[lnps_pkg::IDX_W-1:0];
                            ram_wdata  = start_note;
                            count_next = count_reg + CNT_ONE;
                        end
                        state_next = S_TRD;
                    end else if (count_reg == '0) begin
                        state_next = S_TRD;
                    end else begin
                        state_next = S_SRD;
                    end
                end
            end
            S_SRD: begin
                state_next = S_SCMP;
            end
            S_SCMP: begin
                if (alu_res.eq) begin
                    if (ptr_ext + CNT_ONE == count_reg) begin
                        count_next = count_reg - CNT_ONE;
                        state_next = S_TRD;
                    end else begin
                        state_next = S_MRD;
                    end
                end else if (ptr_ext + CNT_ONE == count_reg) begin
                    // No entry matched: the whole list is dropped.
                    count_next = '0;
                    state_next = S_TRD;
                end else begin
                    ptr_next   = ptr_reg + lnps_pkg::IDX_W'(1);
                    state_next = S_SRD;
                end
            end
            S_MRD: begin
                ram_raddr  = ptr_reg + lnps_pkg::IDX_W'(1);
                state_next = S_MWR;
            end
            S_MWR: begin
                ram_we   = 1'b1;
                ptr_next = ptr_reg + lnps_pkg::IDX_W'(1);
                if (ptr_ext + CNT_TWO == count_reg) begin
                    count_next = count_reg - CNT_ONE;
                    state_next = S_TRD;
                end else begin
                    state_next = S_MRD;
                end
            end
            S_TRD: begin
                ram_raddr = top_addr[lnps_pkg::IDX_W-1:0];
                if (count_reg == '0) begin
                    top_next    = '0;
                    period_next = '0;
                    state_next  = S_DONE;
                end else begin
                    state_next = S_TIDX;
                end
            end
            S_TIDX: begin
                top_next   = ram_rdata;
                idx_next   = alu_res.lt ? lnps_pkg::MOD_TABLE[ram_rdata] : alu_res.diff;
                state_next = S_TPER;
            end
            S_TPER: begin
                period_next = lnps_pkg::PERIOD_TABLE[idx_reg];
                state_next  = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
        ptr_reg    <= ptr_next;
        note_reg   <= note_next;
        top_reg    <= top_next;
        idx_reg    <= idx_next;
        period_reg <= period_next;
    end

    assign idle               = (state_reg == S_IDLE);
    assign done               = (state_reg == S_DONE) && out_free;
    assign result.held_count  = count_reg;
    assign result.active_note = top_reg;
    assign result.period      = period_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_MAX)
        else $error("held count exceeds list size");

    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (done && count_reg == '0) |-> (top_reg == '0 && period_reg == '0))
        else $error("empty list reported a note or period");

    a_note_on_path: assert property (@(posedge aclk) disable iff (!aresetn)
        (idle && start && start_kind == lnps_pkg::KIND_NOTE_ON) |=> (state_reg == S_TRD))
        else $error("note-on did not go straight to the top read");

    a_write_states: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == S_IDLE || state_reg == S_MWR))
        else $error("list written outside append or shift");

endmodule

@@ rtl/core/last_note_priority_stack_unit.sv @@
`timescale 1ns / 1ps

// Channel    Direction  Signals                               Beat contents
// s_ (event) in         s_tvalid s_tready s_tdata s_tuser    note number, kind
// m_ (voice) out        m_tvalid m_tready m_tdata            period, note, count
// cfg        in         cfg_wr_en cfg_wr_data                note offset
//
// A note-on runs the top read, index and period states before the result beat.
// A note-off first reads and compares each entry searched, reads and writes each
// entry moved up, then the same states; the list RAM has a single read port.
// Reset (aresetn low at a clock edge) empties the list and clears the offset.
// A result waits in the output register while m_tready is low; the block
// takes the next event meanwhile and holds its own result until the port frees.
module last_note_priority_stack_unit (
    input  logic                                aclk,
    input  logic                                aresetn,

    // Event input.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // Bits from the lowest up: note_number (7), zero fill.
    input  logic [lnps_pkg::IN_TDATA_W-1:0]     s_tdata,
    // kind: 0 note on, 1 note off.
    input  logic                                s_tuser,

    // Voice output.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // Bits from the lowest up: period (14), active_note (7), held_count (4),
    // zero fill.
    output logic [lnps_pkg::OUT_TDATA_W-1:0]    m_tdata,

    // Note offset register.
    input  logic                                cfg_wr_en,
    input  logic [lnps_pkg::NOTE_W-1:0]         cfg_wr_data
);

    lnps_pkg::note_t                   note_offset_reg;
    logic                              m_tvalid_reg, m_tvalid_next;
    logic [lnps_pkg::OUT_TDATA_W-1:0]  m_tdata_reg, m_tdata_next;

    logic                              ctrl_idle;
    logic                              ctrl_done;
    logic                              out_free;
    lnps_pkg::result_t                 ctrl_result;

    // The output register can take a new beat when it is empty or being drained.
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = ctrl_idle;

    lnps_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (s_tvalid && ctrl_idle),
        .start_kind  (s_tuser),
        .start_note  (s_tdata[lnps_pkg::NOTE_W-1:0]),
        .note_offset (note_offset_reg),
        .out_free    (out_free),
        .idle        (ctrl_idle),
        .done        (ctrl_done),
        .result      (ctrl_result)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (ctrl_done) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = lnps_pkg::OUT_TDATA_W'(ctrl_result);
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            note_offset_reg <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                note_offset_reg <= cfg_wr_data;
            end
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
